// ----- hw/rtl/box_blur_3x3_rgb_top_defines.svh -----
// ---------------------------------------------------------------------------
// box blur assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH

// consequent checked at the same edge as the antecedent
`define BBLUR3_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked at the edge after the antecedent
`define BBLUR3_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bblur3_pkg.sv -----
// ---------------------------------------------------------------------------
// box blur package
// pixel and control types, register indexes and the divide-by-nine helper
// ---------------------------------------------------------------------------
package bblur3_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int FWIDTH_W   = 11;
	localparam int FHEIGHT_W  = 16;
	localparam int OUT_COL_W  = 10;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FWIDTH_W-1:0]  FWIDTH_RESET  = 11'd640;
	localparam logic [FHEIGHT_W-1:0] FHEIGHT_RESET = 16'd480;

	// item kinds
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// reciprocal of nine: floor(s * 7282 / 2^16) equals floor(s / 9) for s < 2304
	localparam logic [12:0] DIV9_MUL   = 13'd7282;
	localparam int          DIV9_SHIFT = 16;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef logic [11:0] sum_t;

	typedef struct packed {
		sum_t red;
		sum_t green;
		sum_t blue;
	} sums_t;

	// per item decisions taken at acceptance
	typedef struct packed {
		logic                 is_pixel;
		logic                 emit;
		logic                 blur;
		logic                 sel_upper;
		logic                 last;
		logic [OUT_COL_W-1:0] col;
		logic [FHEIGHT_W-1:0] row;
	} ctl_t;

	function automatic logic [7:0] div9(input sum_t s);
		logic [24:0] p;
		p = 25'(s) * 25'(DIV9_MUL);
		return p[DIV9_SHIFT +: 8];
	endfunction

endpackage

// ----- hw/rtl/bblur3_in_if.sv -----
// ---------------------------------------------------------------------------
// box blur input channel
// valid/ready channel carrying pixel and drain items
// ---------------------------------------------------------------------------
interface bblur3_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] blue_in;
	logic [7:0] green_in;
	logic [7:0] red_in;

	modport source (output valid, output req_type, output blue_in, output green_in,
		output red_in, input ready);
	modport sink (input valid, input req_type, input blue_in, input green_in,
		input red_in, output ready);
endinterface

// ----- hw/rtl/bblur3_out_if.sv -----
// ---------------------------------------------------------------------------
// box blur output channel
// valid/ready channel carrying filtered pixels with their position
// ---------------------------------------------------------------------------
interface bblur3_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  blue_out;
	logic [7:0]  green_out;
	logic [7:0]  red_out;
	logic [9:0]  out_col;
	logic [15:0] out_row;
	logic        frame_last;

	modport source (output valid, output blue_out, output green_out, output red_out,
		output out_col, output out_row, output frame_last, input ready);
	modport sink (input valid, input blue_out, input green_out, input red_out,
		input out_col, input out_row, input frame_last, output ready);
endinterface

// ----- hw/rtl/bblur3_ram.sv -----
// ---------------------------------------------------------------------------
// box blur line memory
// simple dual port ram, one write port and one registered read port
// ---------------------------------------------------------------------------
module bblur3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/bblur3_ctrl.sv -----
// ---------------------------------------------------------------------------
// box blur control
// frame size registers, input and output position counters and the count
// of pending outputs; decides per item what the pipeline does with it
// ---------------------------------------------------------------------------
`include "box_blur_3x3_rgb_top_defines.svh"

module bblur3_ctrl #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bblur3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bblur3_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                                accept,
	input  logic                                req_type,
	output logic                                take,
	output bblur3_pkg::ctl_t                    ctl,
	output logic [$clog2(MAX_WIDTH)-1:0]        addr
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int NW  = ((WW > bblur3_pkg::FWIDTH_W) ? WW : bblur3_pkg::FWIDTH_W) + 2;
	localparam int PW  = $clog2(MAX_WIDTH + 2);
	localparam int HW  = bblur3_pkg::FHEIGHT_W + 2;

	logic [bblur3_pkg::FWIDTH_W-1:0]  frame_width_q;
	logic [bblur3_pkg::FHEIGHT_W-1:0] frame_height_q;
	logic [AW-1:0]                    in_col_q;
	logic [AW-1:0]                    emit_col_q;
	logic [bblur3_pkg::FHEIGHT_W-1:0] in_row_q;
	logic [bblur3_pkg::FHEIGHT_W-1:0] emit_row_q;
	logic [PW-1:0]                    pending_q;

	logic [NW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [NW-1:0] in_col_w;
	logic [NW-1:0] emit_col_w;
	logic [HW-1:0] in_row_w;
	logic [HW-1:0] emit_row_w;
	logic          is_pixel;
	logic          over;
	logic          in_col_wrap;
	logic          emit_col_wrap;
	logic          in_row_wrap;
	logic          emit_row_wrap;

	// effective frame size and widened counters
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = NW'(1);
		end else if (NW'(frame_width_q) > NW'(MAX_WIDTH)) begin
			w_eff = NW'(MAX_WIDTH);
		end else begin
			w_eff = NW'(frame_width_q);
		end
		h_eff      = (frame_height_q == '0) ? HW'(1) : HW'(frame_height_q);
		in_col_w   = NW'(in_col_q);
		emit_col_w = NW'(emit_col_q);
		in_row_w   = HW'(in_row_q);
		emit_row_w = HW'(emit_row_q);
	end

	// per item decisions
	always_comb begin
		is_pixel      = (req_type == bblur3_pkg::REQ_PIXEL);
		over          = (NW'(pending_q) > w_eff);
		take          = accept && (is_pixel || (pending_q != '0));
		in_col_wrap   = (in_col_w + NW'(1) >= w_eff);
		emit_col_wrap = (emit_col_w + NW'(1) >= w_eff);
		in_row_wrap   = (in_row_w + HW'(1) >= h_eff);
		emit_row_wrap = (emit_row_w + HW'(1) >= h_eff);

		ctl.is_pixel  = is_pixel;
		ctl.emit      = is_pixel ? over : 1'b1;
		ctl.sel_upper = !is_pixel && over;
		ctl.blur      = is_pixel && over
			&& (w_eff >= NW'(3)) && (h_eff >= HW'(3))
			&& (emit_col_w >= NW'(1)) && (emit_col_w + NW'(2) <= w_eff)
			&& (emit_row_w >= HW'(1)) && (emit_row_w + HW'(2) <= h_eff);
		ctl.last      = (emit_row_w + HW'(1) == h_eff) && (emit_col_w + NW'(1) == w_eff);
		ctl.col       = emit_col_w[bblur3_pkg::OUT_COL_W-1:0];
		ctl.row       = emit_row_q;

		addr = is_pixel ? in_col_q : emit_col_q;
	end

	// frame size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= bblur3_pkg::FWIDTH_RESET;
			frame_height_q <= bblur3_pkg::FHEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bblur3_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_wdata[bblur3_pkg::FWIDTH_W-1:0];
				end
				bblur3_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_wdata[bblur3_pkg::FHEIGHT_W-1:0];
				end
			endcase
		end
	end

	// position counters and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			emit_col_q <= '0;
			emit_row_q <= '0;
			pending_q  <= '0;
		end else if (take) begin
			if (is_pixel) begin
				if (in_col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_wrap ? '0 : in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (!over) begin
					pending_q <= pending_q + 1'b1;
				end
			end else begin
				pending_q <= pending_q - 1'b1;
			end
			if (ctl.emit) begin
				if (emit_col_wrap) begin
					emit_col_q <= '0;
					emit_row_q <= emit_row_wrap ? '0 : emit_row_q + 1'b1;
				end else begin
					emit_col_q <= emit_col_q + 1'b1;
				end
			end
		end
	end

	// the last pixel of a frame brings the output position back to the origin
	`BBLUR3_ASSERT_NEXT(a_frame_wrap, take && ctl.emit && ctl.last, (emit_col_q == '0) && (emit_row_q == '0), "output position did not wrap after the last pixel")

endmodule

// ----- hw/rtl/bblur3_pipe.sv -----
// ---------------------------------------------------------------------------
// box blur datapath
// line memory read forwarding, 3x3 window, channel sums and the result
// register, as three elastic stages
// ---------------------------------------------------------------------------
`include "box_blur_3x3_rgb_top_defines.svh"

module bblur3_pipe #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  bblur3_pkg::ctl_t              ctl,
	input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
	input  bblur3_pkg::pix_t              px,
	input  logic [23:0]                   up_rd,
	input  logic [23:0]                   mid_rd,
	output logic                          ready,
	output logic                          ram_we,
	output logic [$clog2(MAX_WIDTH)-1:0]  ram_waddr,
	output logic [23:0]                   up_wr,
	output logic [23:0]                   mid_wr,
	bblur3_out_if.source                  pix_out
);

	localparam int AW = $clog2(MAX_WIDTH);

	// stage one: item with line memory data
	logic              v_s1;
	bblur3_pkg::ctl_t  ctl_s1;
	logic [AW-1:0]     addr_s1;
	bblur3_pkg::pix_t  px_s1;
	logic              fwd_s1;
	bblur3_pkg::pix_t  byp_up_s1;
	bblur3_pkg::pix_t  byp_mid_s1;

	// stage two: sums or passed pixel
	logic                                   v_s2;
	logic                                   blur_s2;
	bblur3_pkg::sums_t                      val_s2;
	logic [bblur3_pkg::OUT_COL_W-1:0]       col_s2;
	logic [bblur3_pkg::FHEIGHT_W-1:0]       row_s2;
	logic                                   last_s2;

	// stage three: result register
	logic                                   v_s3;
	logic [7:0]                             blue_s3;
	logic [7:0]                             green_s3;
	logic [7:0]                             red_s3;
	logic [bblur3_pkg::OUT_COL_W-1:0]       col_s3;
	logic [bblur3_pkg::FHEIGHT_W-1:0]       row_s3;
	logic                                   last_s3;

	bblur3_pkg::pix_t  win_q   [9];
	bblur3_pkg::pix_t  win_nxt [9];
	bblur3_pkg::pix_t  up_eff;
	bblur3_pkg::pix_t  mid_eff;
	bblur3_pkg::pix_t  pass_px;
	bblur3_pkg::sums_t sums;

	logic out_free;
	logic s2_free;
	logic s1_fire;
	logic s2_fire;

	// handshake chain
	always_comb begin
		out_free = !v_s3 || pix_out.ready;
		s2_free  = !v_s2 || out_free;
		s1_fire  = v_s1 && s2_free;
		s2_fire  = v_s2 && out_free;
		ready    = !v_s1 || s2_free;
	end

	// line memory data, forwarded when the previous item wrote the same column
	always_comb begin
		up_eff  = fwd_s1 ? byp_up_s1 : bblur3_pkg::pix_t'(up_rd);
		mid_eff = fwd_s1 ? byp_mid_s1 : bblur3_pkg::pix_t'(mid_rd);
	end

	// line memory write: middle moves up, new pixel into middle
	always_comb begin
		ram_we    = s1_fire && ctl_s1.is_pixel;
		ram_waddr = addr_s1;
		up_wr     = mid_eff;
		mid_wr    = px_s1;
	end

	// shifted window and channel sums
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nxt[r*3]     = win_q[r*3+1];
			win_nxt[r*3 + 1] = win_q[r*3+2];
		end
		win_nxt[2] = up_eff;
		win_nxt[5] = mid_eff;
		win_nxt[8] = px_s1;
		sums = '0;
		for (int k = 0; k < 9; k++) begin
			sums.blue  = sums.blue + bblur3_pkg::sum_t'(win_nxt[k].blue);
			sums.green = sums.green + bblur3_pkg::sum_t'(win_nxt[k].green);
			sums.red   = sums.red + bblur3_pkg::sum_t'(win_nxt[k].red);
		end
		if (ctl_s1.is_pixel) begin
			pass_px = win_nxt[4];
		end else begin
			pass_px = ctl_s1.sel_upper ? up_eff : mid_eff;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready) begin
				v_s1 <= take;
			end
			if (s2_free) begin
				v_s2 <= v_s1 && ctl_s1.emit;
			end
			if (out_free) begin
				v_s3 <= v_s2;
			end
		end
	end

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (ram_we) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= win_nxt[k];
			end
		end
	end

	// stage one payload and forwarding capture
	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1     <= ctl;
			addr_s1    <= addr;
			px_s1      <= px;
			fwd_s1     <= v_s1 && ctl_s1.is_pixel && (addr_s1 == addr);
			byp_up_s1  <= mid_eff;
			byp_mid_s1 <= px_s1;
		end
	end

	// stage two payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			blur_s2 <= ctl_s1.blur;
			col_s2  <= ctl_s1.col;
			row_s2  <= ctl_s1.row;
			last_s2 <= ctl_s1.last;
			if (ctl_s1.blur) begin
				val_s2 <= sums;
			end else begin
				val_s2.blue  <= bblur3_pkg::sum_t'(pass_px.blue);
				val_s2.green <= bblur3_pkg::sum_t'(pass_px.green);
				val_s2.red   <= bblur3_pkg::sum_t'(pass_px.red);
			end
		end
	end

	// result register, divide by nine on blurred pixels
	always_ff @(posedge clk) begin
		if (s2_fire) begin
			if (blur_s2) begin
				blue_s3  <= bblur3_pkg::div9(val_s2.blue);
				green_s3 <= bblur3_pkg::div9(val_s2.green);
				red_s3   <= bblur3_pkg::div9(val_s2.red);
			end else begin
				blue_s3  <= val_s2.blue[7:0];
				green_s3 <= val_s2.green[7:0];
				red_s3   <= val_s2.red[7:0];
			end
			col_s3  <= col_s2;
			row_s3  <= row_s2;
			last_s3 <= last_s2;
		end
	end

	assign pix_out.valid      = v_s3;
	assign pix_out.blue_out   = blue_s3;
	assign pix_out.green_out  = green_s3;
	assign pix_out.red_out    = red_s3;
	assign pix_out.out_col    = col_s3;
	assign pix_out.out_row    = row_s3;
	assign pix_out.frame_last = last_s3;

	`BBLUR3_ASSERT_NOW(a_drain_emits, v_s1 && !ctl_s1.is_pixel, ctl_s1.emit, "drain item in flight without a result")
	`BBLUR3_ASSERT_NOW(a_blur_pixel, v_s1 && ctl_s1.blur, ctl_s1.is_pixel && ctl_s1.emit && !ctl_s1.sel_upper, "blur flagged on an item that is not an emitting pixel")
	`BBLUR3_ASSERT_NEXT(a_fwd_match, take, fwd_s1 == ($past(ram_we) && ($past(ram_waddr) == addr_s1)), "forwarding flag disagrees with the line memory write")

endmodule

// ----- hw/rtl/box_blur_3x3_rgb_top.sv -----
// ---------------------------------------------------------------------------
// 3x3 box blur, rgb
// raster stream box filter with two line memories and a 3x3 window
// ---------------------------------------------------------------------------
// Usage
//  - pix_in takes pixel items (req_type 0) in raster order, or drain items
//    (req_type 1) that flush one pending output each; a drain with nothing
//    pending is taken and gives no item.
//  - pix_out gives one pixel per emitting item, in raster order, with its
//    column, row and a last-of-frame flag; output lags input by one row plus
//    one pixel, so width + 1 drains flush the end of a frame.
//  - frame_width (index 0) and frame_height (index 1) are written through the
//    cfg port while the block is idle.
//  - throughput is one item per clock while pix_out takes its results; the edge
//    that accepts an item loads the input stage and the line memory read, then
//    the sum stage, then the result register, from which the result is valid.
//  - when pix_out stalls, the three stages fill up and pix_in.ready drops only
//    once the first stage cannot move on.
//  - reset clears the window, counters and pending count and loads 640 x 480;
//    line memories are not cleared and hold nothing valid until written.
// ---------------------------------------------------------------------------
module box_blur_3x3_rgb_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bblur3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bblur3_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bblur3_in_if.sink                         pix_in,
	bblur3_out_if.source                      pix_out
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic              ready;
	logic              accept;
	logic              take;
	bblur3_pkg::ctl_t  ctl;
	logic [AW-1:0]     addr;
	bblur3_pkg::pix_t  px;
	logic [23:0]       up_rd;
	logic [23:0]       mid_rd;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [23:0]       up_wr;
	logic [23:0]       mid_wr;

	// input handshake and pixel packing
	assign pix_in.ready = ready;
	assign accept       = pix_in.valid && ready;
	assign px.blue      = pix_in.blue_in;
	assign px.green     = pix_in.green_in;
	assign px.red       = pix_in.red_in;

	bblur3_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.req_type  (pix_in.req_type),
		.take      (take),
		.ctl       (ctl),
		.addr      (addr)
	);

	// upper line memory
	bblur3_ram #(
		.WIDTH (24),
		.DEPTH (MAX_WIDTH)
	) u_upper_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (up_wr),
		.re    (take),
		.raddr (addr),
		.rdata (up_rd)
	);

	// middle line memory
	bblur3_ram #(
		.WIDTH (24),
		.DEPTH (MAX_WIDTH)
	) u_middle_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (mid_wr),
		.re    (take),
		.raddr (addr),
		.rdata (mid_rd)
	);

	bblur3_pipe #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.ctl       (ctl),
		.addr      (addr),
		.px        (px),
		.up_rd     (up_rd),
		.mid_rd    (mid_rd),
		.ready     (ready),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.up_wr     (up_wr),
		.mid_wr    (mid_wr),
		.pix_out   (pix_out)
	);

endmodule

// ----- sim/box_blur_3x3_rgb_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// box blur 3x3 rgb testbench
// feeds pixel and drain items through a random-stall valid/ready channel,
// predicts every output pixel with an in-bench filter model and checks each
// field of each output item, over a run of frame sizes written between phases
// ---------------------------------------------------------------------------
module box_blur_3x3_rgb_top_tb;
	import bblur3_pkg::*;

	localparam int          MAX_W       = 1024;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned TAIL_CYCLES = 8;
	localparam int unsigned RAND_ITEMS  = 1150;

	// one expected output pixel
	typedef struct packed {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [9:0]  col;
		logic [15:0] row;
		logic        last;
	} blur_res_t;

	// one input item with the output it is due to cause
	typedef struct {
		logic      kind;
		pix_t      px;
		bit        has_res;
		blur_res_t res;
	} blur_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bblur3_in_if  in_ch();
	bblur3_out_if out_ch();

	box_blur_3x3_rgb_top #(
		.MAX_WIDTH(MAX_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pix_in(in_ch),
		.pix_out(out_ch)
	);

	always #10 clk = ~clk;

	// filter model state, with a written flag per stored pixel
	pix_t           up_line [MAX_W];
	pix_t           mid_line [MAX_W];
	bit             up_ok [MAX_W];
	bit             mid_ok [MAX_W];
	pix_t           win [9];
	bit             win_ok [9];
	int unsigned    in_col, in_row, em_col, em_row, pend;
	logic [10:0]    reg_width;
	logic [15:0]    reg_height;

	blur_req_t      pixel_feed_q [$];
	blur_res_t      blurred_q [$];
	blur_req_t      cur_item;
	int unsigned    queued_cnt, offered_cnt, taken_cnt, n_fail, cycle_cnt;
	bit             steady;

	function automatic void filter_reset();
		foreach (up_ok[i]) begin
			up_ok[i]  = 1'b0;
			mid_ok[i] = 1'b0;
		end
		foreach (win[i]) begin
			win[i]    = '0;
			win_ok[i] = 1'b1;
		end
		in_col     = 0;
		in_row     = 0;
		em_col     = 0;
		em_row     = 0;
		pend       = 0;
		reg_width  = FWIDTH_RESET;
		reg_height = FHEIGHT_RESET;
	endfunction

	function automatic int unsigned act_width();
		if (reg_width == 0)
			return 1;
		if (reg_width > MAX_W)
			return MAX_W;
		return 32'(reg_width);
	endfunction

	function automatic int unsigned act_height();
		return (reg_height == 0) ? 1 : 32'(reg_height);
	endfunction

	function automatic int unsigned line_idx(input int unsigned c);
		return (c < MAX_W) ? c : 0;
	endfunction

	// raster advance of a column/row pair, wrapping at the frame bounds
	function automatic void step_pos(inout int unsigned c, inout int unsigned r,
		input int unsigned w, input int unsigned h);
		if (c + 1 >= w) begin
			c = 0;
			r = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			c = c + 1;
		end
	endfunction

	function automatic bit is_interior(input int unsigned w, input int unsigned h);
		return w >= 3 && h >= 3 && em_col >= 1 && em_col + 2 <= w &&
			em_row >= 1 && em_row + 2 <= h;
	endfunction

	function automatic blur_res_t emit_pixel(input pix_t src, input int unsigned w,
		input int unsigned h);
		blur_res_t r;
		r.blue  = src.blue;
		r.green = src.green;
		r.red   = src.red;
		r.col   = em_col[9:0];
		r.row   = em_row[15:0];
		r.last  = (em_row + 1 == h && em_col + 1 == w);
		step_pos(em_col, em_row, w, h);
		return r;
	endfunction

	// true when the item would put a never-written line entry into its output
	function automatic bit feeds_stale(input logic kind);
		int unsigned w, idx;
		w = act_width();
		if (kind == REQ_DRAIN) begin
			if (pend == 0)
				return 1'b0;
			idx = line_idx(em_col);
			return (pend > w) ? !up_ok[idx] : !mid_ok[idx];
		end
		if (pend < w + 1)
			return 1'b0;
		idx = line_idx(in_col);
		if (is_interior(w, act_height()))
			return !(win_ok[1] && win_ok[2] && win_ok[4] && win_ok[5] && win_ok[7] &&
				win_ok[8] && up_ok[idx] && mid_ok[idx]);
		return !win_ok[5];
	endfunction

	// one item through the filter; returns 1 when it gives an output pixel
	function automatic bit filter_step(input logic kind, input pix_t px,
		output blur_res_t res);
		int unsigned w, h, idx, r;
		logic [11:0] sb, sg, sr;
		pix_t src;
		w   = act_width();
		h   = act_height();
		res = '0;
		if (kind == REQ_DRAIN) begin
			if (pend == 0)
				return 1'b0;
			idx = line_idx(em_col);
			src = (pend > w) ? up_line[idx] : mid_line[idx];
			pend--;
			res = emit_pixel(src, w, h);
			return 1'b1;
		end
		// shift the window left and load the new column
		idx = line_idx(in_col);
		for (r = 0; r < 3; r++) begin
			win[r*3]        = win[r*3+1];
			win[r*3+1]      = win[r*3+2];
			win_ok[r*3]     = win_ok[r*3+1];
			win_ok[r*3+1]   = win_ok[r*3+2];
		end
		win[2]        = up_line[idx];
		win[5]        = mid_line[idx];
		win[8]        = px;
		win_ok[2]     = up_ok[idx];
		win_ok[5]     = mid_ok[idx];
		win_ok[8]     = 1'b1;
		up_line[idx]  = mid_line[idx];
		up_ok[idx]    = mid_ok[idx];
		mid_line[idx] = px;
		mid_ok[idx]   = 1'b1;
		step_pos(in_col, in_row, w, h);
		if (pend < w + 1) begin
			pend++;
			return 1'b0;
		end
		if (is_interior(w, h)) begin
			sb = '0;
			sg = '0;
			sr = '0;
			foreach (win[k]) begin
				sb += 12'(win[k].blue);
				sg += 12'(win[k].green);
				sr += 12'(win[k].red);
			end
			src.blue  = 8'(sb / 9);
			src.green = 8'(sg / 9);
			src.red   = 8'(sr / 9);
		end else begin
			src = win[4];
		end
		res = emit_pixel(src, w, h);
		return 1'b1;
	endfunction

	function automatic pix_t rand_pix();
		pix_t p;
		p = pix_t'(24'($urandom));
		if ($urandom_range(0, 6) == 0) begin
			p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return p;
	endfunction

	// predict an item and queue it for the driver, unless it would feed a never-written line entry
	task automatic offer(input logic kind, input pix_t px);
		blur_req_t it;
		if (feeds_stale(kind))
			return;
		it.kind    = kind;
		it.px      = px;
		it.has_res = filter_step(kind, px, it.res);
		pixel_feed_q.push_back(it);
		queued_cnt++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == REG_FRAME_WIDTH)
			reg_width = data[10:0];
		else
			reg_height = data[15:0];
	endtask

	task automatic set_frame(input logic [10:0] w, input logic [15:0] h);
		logic [4:0] junk;
		junk = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0;
		write_reg(REG_FRAME_WIDTH, {junk, w});
		write_reg(REG_FRAME_HEIGHT, h);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every queued item is taken and every output pixel is back
	task automatic settle();
		while (pixel_feed_q.size() != 0 || taken_cnt != queued_cnt || blurred_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input int phase);
		logic [10:0] wd;
		logic [15:0] hd;
		int unsigned w, h, budget, n_pix, k;
		bit cut;
		budget = $urandom_range(30, 70);
		wd     = 11'($urandom_range(1, 9));
		hd     = 16'($urandom_range(1, 7));
		case (phase)
			3: begin
				wd = 11'd0;
				hd = 16'd0;
			end
			7: begin
				wd     = 11'd1024;
				hd     = 16'd2;
				budget = 30;
			end
			11: begin
				wd     = 11'h7FF;
				hd     = 16'hFFFF;
				budget = 25;
			end
			15: begin
				wd = 11'd1;
				hd = 16'hFFFF;
			end
			19: begin
				wd = 11'd5;
				hd = 16'd1;
			end
			default: ;
		endcase
		set_frame(wd, hd);
		steady = (phase % 5 == 2);
		w = act_width();
		h = act_height();
		if ($urandom_range(0, 7) == 0) begin
			// unstructured mix of pixels and drains
			repeat (budget)
				offer($urandom_range(0, 1) ? REQ_DRAIN : REQ_PIXEL, rand_pix());
		end else begin
			// whole frames, sometimes cut short so the next size lands mid-frame
			cut   = ($urandom_range(0, 3) == 0) || (w * h > budget);
			n_pix = (w * h > budget) ? budget : (budget / (w * h)) * w * h;
			if (cut)
				n_pix = n_pix - $urandom_range(0, n_pix / 2);
			for (k = 0; k < n_pix; k++) begin
				if ($urandom_range(0, 99) < 4)
					offer(REQ_DRAIN, rand_pix());
				offer(REQ_PIXEL, rand_pix());
			end
			if (!cut)
				repeat (pend + $urandom_range(0, 2))
					offer(REQ_DRAIN, rand_pix());
		end
		settle();
	endtask

	// stimulus
	initial begin
		pix_t corner_px [9];
		int   phase;
		corner_px = '{{8'h00, 8'h00, 8'h00}, {8'hFF, 8'hFF, 8'hFF}, {8'hAA, 8'h55, 8'h0F},
			{8'h80, 8'h01, 8'hFE}, {8'hFF, 8'hFF, 8'hFF}, {8'h55, 8'hAA, 8'hF0},
			{8'h7F, 8'h80, 8'h01}, {8'hFF, 8'h00, 8'hFF}, {8'h01, 8'hFE, 8'h80}};
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_FRAME_WIDTH;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.req_type  = REQ_PIXEL;
		in_ch.blue_in   = '0;
		in_ch.green_in  = '0;
		in_ch.red_in    = '0;
		out_ch.ready    = 1'b0;
		steady          = 1'b0;
		queued_cnt      = 0;
		filter_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 3x3 frame: drain on empty, interior blur, edges, flush, drain on empty
		set_frame(11'd3, 16'd3);
		offer(REQ_DRAIN, rand_pix());
		foreach (corner_px[i])
			offer(REQ_PIXEL, corner_px[i]);
		repeat (5)
			offer(REQ_DRAIN, rand_pix());
		settle();

		// narrow frame passes through whole
		set_frame(11'd2, 16'd3);
		repeat (6)
			offer(REQ_PIXEL, rand_pix());
		repeat (3)
			offer(REQ_DRAIN, rand_pix());
		settle();

		phase = 0;
		while (queued_cnt < RAND_ITEMS + 24) begin
			random_phase(phase);
			phase++;
		end

		if (n_fail == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || taken_cnt == offered_cnt) begin
				if (pixel_feed_q.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
					cur_item = pixel_feed_q.pop_front();
					offered_cnt++;
					in_ch.valid    <= 1'b1;
					in_ch.req_type <= cur_item.kind;
					in_ch.blue_in  <= cur_item.px.blue;
					in_ch.green_in <= cur_item.px.green;
					in_ch.red_in   <= cur_item.px.red;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// output back-pressure
	always @(negedge clk) begin
		if (arst_n)
			out_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
	end

	// accepted input items hand their expected output over
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			taken_cnt++;
			if (cur_item.has_res)
				blurred_q.push_back(cur_item.res);
		end
	end

	function automatic void compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endfunction

	// output checker
	always @(posedge clk) begin
		blur_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (blurred_q.size() == 0) begin
				$error("unexpected output item at col %0d row %0d", out_ch.out_col,
					out_ch.out_row);
				n_fail++;
			end else begin
				want = blurred_q.pop_front();
				compare_field("blue_out", 16'(want.blue), 16'(out_ch.blue_out));
				compare_field("green_out", 16'(want.green), 16'(out_ch.green_out));
				compare_field("red_out", 16'(want.red), 16'(out_ch.red_out));
				compare_field("out_col", 16'(want.col), 16'(out_ch.out_col));
				compare_field("out_row", want.row, out_ch.out_row);
				compare_field("frame_last", 16'(want.last), 16'(out_ch.frame_last));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
